>>> design/labeled_adjacency_matrix_macros.svh
// ----------------------------------------------------------------------------
// labeled adjacency matrix assertion macros
// Shared property macros for the graph store; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef LABELED_ADJACENCY_MATRIX_MACROS_SVH
`define LABELED_ADJACENCY_MATRIX_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define LAM_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LAM_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LAM_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define LAM_ASSERT_NXT(name, clk, rst, ante, cons, msg)
`endif

`endif

>>> design/lam_pkg.sv
// ----------------------------------------------------------------------------
// lam_pkg
// Types, command codes and default sizes of the labeled adjacency matrix.
// ----------------------------------------------------------------------------
package lam_pkg;

  // default sizes
  localparam int LAM_MAX_VERTICES = 16;
  localparam int LAM_LABEL_BITS   = 32;

  // fixed field widths
  localparam int VCOUNT_W    = 5;
  localparam int VERTEX_W    = 4;
  localparam int LABEL_OUT_W = 32;
  localparam int EDGES_W     = 9;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

  // command codes
  typedef enum logic [2:0] {
    CMD_SET = 3'd0,
    CMD_GET = 3'd1,
    CMD_REM = 3'd2,
    CMD_OUT = 3'd3,
    CMD_IN  = 3'd4,
    CMD_ADJ = 3'd5
  } cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_EXEC,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // one result beat
  typedef struct packed {
    logic                   status;
    logic                   found;
    logic [LABEL_OUT_W-1:0] label_out;
    logic [VERTEX_W-1:0]    neighbor;
    logic                   neighbor_valid;
    logic [EDGES_W-1:0]     edges_now;
    logic                   last;
  } result_t;

endpackage

>>> design/lam_ram.sv
// ----------------------------------------------------------------------------
// lam_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/labeled_adjacency_matrix.sv
// ----------------------------------------------------------------------------
// labeled_adjacency_matrix
// Directed graph store with presence bits, edge labels and an edge count.
// ----------------------------------------------------------------------------
// The block takes one command at a time. Set, get and remove go from accept
// through a memory read to update and result. The outgoing, incoming and
// adjacent list commands go from accept through an issue step to a scan of
// each vertex below the vertex count, then a final beat; adjacent scans both
// directions, outgoing first. The scan rate is set by the single read port
// of the presence memory, which is organized one matrix row per word: an
// outgoing scan walks the bits of one row, an incoming scan reads one row per
// cycle unless stalled. A stalled result output holds the scan in place when
// a hit must send the pending neighbor. After reset the presence memory is
// cleared one row a cycle, all MAX_VERTICES rows, and no command is accepted until that pass is done.
// ----------------------------------------------------------------------------
`include "labeled_adjacency_matrix_macros.svh"

module labeled_adjacency_matrix
  import lam_pkg::*;
#(
  parameter int MAX_VERTICES = LAM_MAX_VERTICES,
  parameter int LABEL_BITS   = LAM_LABEL_BITS
) (
  input  logic                clk,
  input  logic                rst,
  // configuration: vertex count
  input  logic                cfg_we,
  input  logic [VCOUNT_W-1:0] cfg_wdata,
  // command beats
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,   // src_vertex, dst_vertex, label_in
  input  logic [2:0]          s_tuser,   // cmd
  // result beats
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [47:0]         m_tdata,   // label_out, neighbor, edges_now, zero pad
  output logic [2:0]          m_tuser,   // status, found, neighbor_valid
  output logic                m_tlast
);

  localparam int IW     = $clog2(MAX_VERTICES);
  localparam int LW     = IW + 1;
  localparam int AW     = 2 * IW;
  localparam int LDEPTH = 1 << AW;
  localparam int CELLS  = MAX_VERTICES * MAX_VERTICES;
  localparam int CNTW   = $clog2(CELLS + 1);

  // state
  state_t                state, state_next;
  logic [IW-1:0]         clr_row, clr_row_next;
  cmd_t                  cmd_r;
  logic [VERTEX_W-1:0]   src_r, dst_r;
  logic [LABEL_OUT_W-1:0] lab_r;
  logic [VCOUNT_W-1:0]   vcount;
  logic [CNTW-1:0]       edge_total, edge_total_next;
  logic [IW-1:0]         idx, idx_next;
  logic                  dir_in, dir_in_next;
  logic                  pend_valid, pend_valid_next;
  logic [IW-1:0]         pend_idx, pend_idx_next;
  logic                  load;

  // memory ports
  logic                  p_we;
  logic [IW-1:0]         p_waddr, p_raddr;
  logic [MAX_VERTICES-1:0] p_wdata, p_rdata;
  logic                  l_we;
  logic [AW-1:0]         l_addr;
  logic [LABEL_BITS-1:0] l_wdata, l_rdata;

  // result path
  result_t               res;
  logic                  emit;
  logic                  out_free;

  // decoded command fields
  logic [7:0]            lim8;
  logic [LW-1:0]         limit;
  logic                  src_ok, dst_ok, v_ok, list_cmd, hit, present;
  logic [IW-1:0]         src_row, dst_row, v_row;
  logic [MAX_VERTICES-1:0] dst_mask;

  lam_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_present (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  lam_ram #(
    .WIDTH (LABEL_BITS),
    .DEPTH (LDEPTH)
  ) u_labels (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_addr),
    .wdata (l_wdata),
    .raddr (l_addr),
    .rdata (l_rdata)
  );

  // vertex range and row selection
  always_comb begin
    lim8     = ({3'b000, vcount} > 8'(MAX_VERTICES)) ? 8'(MAX_VERTICES)
                                                     : {3'b000, vcount};
    limit    = lim8[LW-1:0];
    src_ok   = {4'b0000, src_r} < lim8;
    dst_ok   = {4'b0000, dst_r} < lim8;
    src_row  = IW'(src_r);
    dst_row  = IW'(dst_r);
    list_cmd = (cmd_r == CMD_OUT) || (cmd_r == CMD_IN) || (cmd_r == CMD_ADJ);
    v_ok     = (cmd_r == CMD_IN) ? dst_ok : src_ok;
    v_row    = (cmd_r == CMD_IN) ? dst_row : src_row;
    dst_mask = MAX_VERTICES'(1) << dst_row;
    present  = p_rdata[dst_row];
    hit      = dir_in ? p_rdata[v_row] : p_rdata[idx];
    l_addr   = {src_row, dst_row};
    l_wdata  = LABEL_BITS'(lab_r);
    out_free = !m_tvalid || m_tready;
    s_tready = (state == ST_IDLE);
    load     = s_tvalid && s_tready;
  end

  // sequencer: next state, memory writes and result beat
  always_comb begin
    state_next      = state;
    clr_row_next    = clr_row;
    edge_total_next = edge_total;
    idx_next        = idx;
    dir_in_next     = dir_in;
    pend_valid_next = pend_valid;
    pend_idx_next   = pend_idx;
    p_we            = 1'b0;
    p_waddr         = src_row;
    p_wdata         = '0;
    l_we            = 1'b0;
    emit            = 1'b0;
    res             = '0;

    unique case (state)
      ST_CLEAR: begin
        p_we         = 1'b1;
        p_waddr      = clr_row;
        clr_row_next = clr_row + IW'(1);
        if (clr_row == IW'(MAX_VERTICES - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (load) begin
          state_next = ST_ISSUE;
        end
      end

      ST_ISSUE: begin
        dir_in_next     = (cmd_r == CMD_IN);
        idx_next        = '0;
        pend_valid_next = 1'b0;
        state_next      = (list_cmd && v_ok) ? ST_SCAN : ST_EXEC;
      end

      ST_EXEC: begin
        if (out_free) begin
          emit       = 1'b1;
          res.last   = 1'b1;
          state_next = ST_IDLE;
          if (list_cmd) begin
            res.status = 1'b1;
          end else begin
            unique case (cmd_r)
              CMD_SET: begin
                if (src_ok && dst_ok) begin
                  p_we    = 1'b1;
                  p_wdata = p_rdata | dst_mask;
                  l_we    = 1'b1;
                  if (!present) begin
                    edge_total_next = edge_total + CNTW'(1);
                  end
                end else begin
                  res.status = 1'b1;
                end
              end
              CMD_GET: begin
                if (src_ok && dst_ok) begin
                  res.found = present;
                  if (present) begin
                    res.label_out = LABEL_OUT_W'(signed'(l_rdata));
                  end
                end else begin
                  res.status = 1'b1;
                end
              end
              CMD_REM: begin
                if (src_ok && dst_ok) begin
                  res.found = present;
                  if (present) begin
                    p_we            = 1'b1;
                    p_wdata         = p_rdata & ~dst_mask;
                    edge_total_next = edge_total - CNTW'(1);
                  end
                end else begin
                  res.status = 1'b1;
                end
              end
              default: begin
                // unused command codes give a plain result
              end
            endcase
          end
        end
      end

      ST_SCAN: begin
        // a hit with a neighbor still pending must wait for the output
        if (!(hit && pend_valid && !out_free)) begin
          if (hit && pend_valid) begin
            emit               = 1'b1;
            res.neighbor       = VERTEX_W'(pend_idx);
            res.neighbor_valid = 1'b1;
          end
          if (hit) begin
            pend_valid_next = 1'b1;
            pend_idx_next   = idx;
          end
          if ((LW'(idx) + LW'(1)) == limit) begin
            if ((cmd_r == CMD_ADJ) && !dir_in) begin
              dir_in_next = 1'b1;
              idx_next    = '0;
            end else begin
              state_next = ST_FINISH;
            end
          end else begin
            idx_next = idx + IW'(1);
          end
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          emit               = 1'b1;
          res.neighbor       = pend_valid ? VERTEX_W'(pend_idx) : '0;
          res.neighbor_valid = pend_valid;
          res.last           = 1'b1;
          state_next         = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res.edges_now = EDGES_W'(edge_total_next);
    // read the row that the next cycle examines
    if ((state == ST_ISSUE) && !list_cmd) begin
      p_raddr = src_row;
    end else begin
      p_raddr = dir_in_next ? idx_next : v_row;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_row    <= '0;
      vcount     <= VCOUNT_RESET;
      edge_total <= '0;
      idx        <= '0;
      dir_in     <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      clr_row    <= clr_row_next;
      edge_total <= edge_total_next;
      idx        <= idx_next;
      dir_in     <= dir_in_next;
      pend_valid <= pend_valid_next;
      if (cfg_we) begin
        vcount <= cfg_wdata;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    pend_idx <= pend_idx_next;
    if (load) begin
      cmd_r <= cmd_t'(s_tuser);
      src_r <= s_tdata[3:0];
      dst_r <= s_tdata[7:4];
      lab_r <= s_tdata[39:8];
    end
    if (emit) begin
      m_tdata <= {3'b000, res.edges_now, res.neighbor, res.label_out};
      m_tuser <= {res.neighbor_valid, res.found, res.status};
      m_tlast <= res.last;
    end
  end

  // checks
  `LAM_ASSERT_IMP(a_found_plain, clk, rst, m_tvalid && m_tuser[1],
                  !m_tuser[0] && !m_tuser[2], "found beat carries error or neighbor")
  `LAM_ASSERT_IMP(a_more_pending, clk, rst, m_tvalid && m_tready && !m_tlast,
                  !s_tready, "command taken before all results delivered")
  `LAM_ASSERT_NXT(a_count_step, clk, rst, state != ST_EXEC,
                  edge_total == $past(edge_total) || $past(state) == ST_EXEC,
                  "edge count moved outside an update")

endmodule
